// ===== hw/rtl/sefc_pkg.sv =====
`timescale 1ns / 1ps

package sefc_pkg;

    // Frame layout
    localparam int FRAME_W     = 48;
    localparam int POS_W       = 20;
    localparam int ANGLE_W     = 22;
    localparam int CRC_W       = 7;
    localparam int CRC_DATA_W  = 26;     // frame bits 32..7
    localparam int PROD_W      = 42;     // POS_W + width of ANGLE_SCALE

    localparam logic [CRC_W-1:0]   CRC_POLY    = 7'h5B;
    localparam logic [ANGLE_W-1:0] ANGLE_SCALE = 22'd3600000;
    localparam logic [PROD_W-1:0]  ANGLE_HALF  = 42'h80000;

    // Input transaction
    typedef struct packed {
        logic               power_on;
        logic               read_enable;
        logic               sequence_busy;
        logic [FRAME_W-1:0] frame;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic               read_active;
        logic               position_valid;
        logic               error_not_valid;
        logic               error_crc;
        logic [ANGLE_W-1:0] angle;
        logic [POS_W-1:0]   raw_position;
        logic               flag_bit32;
        logic               flag_bit30;
        logic               flag_bit7;
        logic [CRC_W-1:0]   crc_received;
        logic [CRC_W-1:0]   crc_computed;
    } t_out;

    // Decoded frame, decode unit to top level
    typedef struct packed {
        logic               gate;
        logic               frame_ok;
        logic               bit31;
        logic               crc_bad;
        logic               bit32;
        logic               bit30;
        logic               bit7;
        logic [POS_W-1:0]   pos;
        logic [CRC_W-1:0]   rcv;
        logic [CRC_W-1:0]   calc;
        logic [ANGLE_W-1:0] angle;
    } t_dec;

    typedef logic [CRC_W-1:0][CRC_DATA_W-1:0] t_crc_mat;

    // Bit-serial augmented CRC-7, MSB first; only evaluated at elaboration
    function automatic logic [CRC_W-1:0] crc7_serial(input logic [CRC_DATA_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             top;
        crc = '0;
        for (int i = CRC_DATA_W - 1; i >= 0; i--) begin
            top = crc[CRC_W-1];
            crc = {crc[CRC_W-2:0], data[i]};
            if (top) begin
                crc = crc ^ CRC_POLY;
            end
        end
        for (int i = 0; i < CRC_W; i++) begin
            top = crc[CRC_W-1];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (top) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // The CRC is linear: column i is the CRC of a single set data bit
    function automatic t_crc_mat crc7_matrix();
        t_crc_mat         m;
        logic [CRC_W-1:0] c;
        m = '0;
        for (int i = 0; i < CRC_DATA_W; i++) begin
            c = crc7_serial(CRC_DATA_W'(1) << i);
            for (int j = 0; j < CRC_W; j++) begin
                m[j][i] = c[j];
            end
        end
        return m;
    endfunction

    localparam t_crc_mat CRC_MAT = crc7_matrix();

endpackage

// ===== hw/rtl/sefc_decode.sv =====
`timescale 1ns / 1ps

// Field extraction, CRC XOR tree and angle scaling for one frame
module sefc_decode (
    input  sefc_pkg::t_in  i_item,
    output sefc_pkg::t_dec o_dec
);

    logic [sefc_pkg::CRC_DATA_W-1:0] crc_data;
    logic [sefc_pkg::CRC_W-1:0]      calc;
    logic [sefc_pkg::PROD_W-1:0]     prod;
    logic [sefc_pkg::PROD_W-1:0]     rounded;

    assign crc_data = i_item.frame[32:7];

    // Each CRC bit is the parity of a fixed subset of the data bits
    always_comb begin
        for (int j = 0; j < sefc_pkg::CRC_W; j++) begin
            calc[j] = ^(crc_data & sefc_pkg::CRC_MAT[j]);
        end
    end

    // angle = (pos * 3600000 + 2^19) >> 20
    assign prod    = sefc_pkg::PROD_W'(i_item.frame[27:8]) *
                     sefc_pkg::PROD_W'(sefc_pkg::ANGLE_SCALE);
    assign rounded = prod + sefc_pkg::ANGLE_HALF;

    always_comb begin
        o_dec.gate     = i_item.power_on & i_item.read_enable & ~i_item.sequence_busy;
        o_dec.bit31    = i_item.frame[31];
        o_dec.crc_bad  = (i_item.frame[6:0] != calc);
        o_dec.frame_ok = i_item.frame[31] & ~o_dec.crc_bad;
        o_dec.bit32    = i_item.frame[32];
        o_dec.bit30    = i_item.frame[30];
        o_dec.bit7     = i_item.frame[7];
        o_dec.pos      = i_item.frame[27:8];
        o_dec.rcv      = i_item.frame[6:0];
        o_dec.calc     = calc;
        o_dec.angle    = rounded[sefc_pkg::PROD_W-1:20];
    end

endmodule

// ===== hw/rtl/ssi_encoder_frame_checker.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall  | i_in_data  (sefc_pkg::t_in)
// result  | out       | o_out_valid / i_out_stall | o_out_data (sefc_pkg::t_out)
//
// One transaction per cycle sustained while i_out_stall is low; input register, then
// result register. Decode, CRC tree and the angle multiply sit between them.
// Each input transaction gives exactly one result transaction.
// Reset (i_rst_n low, synchronous) empties both stages and zeroes the held state.
// A stalled result holds; the input register still takes one more transaction.
module ssi_encoder_frame_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sefc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sefc_pkg::t_out o_out_data
);

    logic           r_s1_valid, n_s1_valid;
    sefc_pkg::t_in  r_s1_data;
    logic           r_out_valid, n_out_valid;
    sefc_pkg::t_out r_out_data, n_out_data;

    logic [sefc_pkg::ANGLE_W-1:0] r_held_angle, n_held_angle;
    logic [sefc_pkg::POS_W-1:0]   r_held_pos, n_held_pos;
    logic [1:0]                   r_held_err, n_held_err;       // {not valid, crc}
    logic [2:0]                   r_held_status, n_held_status; // {b32, b30, b7}
    logic [2*sefc_pkg::CRC_W-1:0] r_held_crc, n_held_crc;       // {rcv, calc}

    sefc_pkg::t_dec dec;
    logic           out_open, in_fire, s1_fire, out_fire;

    sefc_decode u_decode (
        .i_item (r_s1_data),
        .o_dec  (dec)
    );

    // Handshake
    assign out_open   = ~r_out_valid | ~i_out_stall;
    assign s1_fire    = r_s1_valid & out_open;
    assign out_fire   = r_out_valid & ~i_out_stall;
    assign o_in_stall = r_s1_valid & ~out_open;
    assign in_fire    = i_in_valid & ~o_in_stall;

    assign n_s1_valid  = in_fire | (r_s1_valid & ~s1_fire);
    assign n_out_valid = s1_fire | (r_out_valid & ~out_fire);

    // Held state update for a decoded frame
    always_comb begin
        n_held_angle  = r_held_angle;
        n_held_pos    = r_held_pos;
        n_held_err    = r_held_err;
        n_held_status = r_held_status;
        n_held_crc    = r_held_crc;
        if (s1_fire && dec.gate) begin
            n_held_pos    = dec.pos;
            n_held_status = {dec.bit32, dec.bit30, dec.bit7};
            n_held_crc    = {dec.rcv, dec.calc};
            if (dec.frame_ok) begin
                n_held_err   = 2'b00;
                n_held_angle = dec.angle;
            end else begin
                n_held_err = {~dec.bit31, dec.crc_bad};
            end
        end
    end

    // Result assembly
    always_comb begin
        n_out_data.read_active     = dec.gate;
        n_out_data.position_valid  = dec.gate & dec.frame_ok;
        n_out_data.error_not_valid = n_held_err[1];
        n_out_data.error_crc       = n_held_err[0];
        n_out_data.angle           = n_held_angle;
        n_out_data.raw_position    = n_held_pos;
        n_out_data.flag_bit32      = n_held_status[2];
        n_out_data.flag_bit30      = n_held_status[1];
        n_out_data.flag_bit7       = n_held_status[0];
        n_out_data.crc_received    = n_held_crc[2*sefc_pkg::CRC_W-1:sefc_pkg::CRC_W];
        n_out_data.crc_computed    = n_held_crc[sefc_pkg::CRC_W-1:0];
    end

    // Control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_held_angle  <= '0;
            r_held_pos    <= '0;
            r_held_err    <= '0;
            r_held_status <= '0;
            r_held_crc    <= '0;
        end else begin
            r_s1_valid    <= n_s1_valid;
            r_out_valid   <= n_out_valid;
            r_held_angle  <= n_held_angle;
            r_held_pos    <= n_held_pos;
            r_held_err    <= n_held_err;
            r_held_status <= n_held_status;
            r_held_crc    <= n_held_crc;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_data <= i_in_data;
        end
        if (s1_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/sefc_checker.sv =====
`timescale 1ns / 1ps

module sefc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input sefc_pkg::t_out o_out_data
);

    // A valid position only comes from a decoded frame
    a_valid_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.position_valid |-> o_out_data.read_active)
        else $error("position_valid without read_active");

    // A valid position clears both error flags
    a_valid_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.position_valid |->
            !o_out_data.error_not_valid && !o_out_data.error_crc)
        else $error("error flag set on a valid position");

    // A decoded but rejected frame names at least one cause
    a_reject_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_active && !o_out_data.position_valid |->
            o_out_data.error_not_valid || o_out_data.error_crc)
        else $error("rejected frame without error cause");

    // The held CRC error agrees with the held CRC pair
    a_crc_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.error_crc == (o_out_data.crc_received != o_out_data.crc_computed))
        else $error("error_crc disagrees with CRC pair");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind ssi_encoder_frame_checker sefc_checker u_sefc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAME_W    = sefc_pkg::FRAME_W;
    localparam int POS_W      = sefc_pkg::POS_W;
    localparam int ANGLE_W    = sefc_pkg::ANGLE_W;
    localparam int CRC_W      = sefc_pkg::CRC_W;
    localparam int CRC_DATA_W = sefc_pkg::CRC_DATA_W;
    localparam logic [CRC_W-1:0] CRC_POLY = sefc_pkg::CRC_POLY;

    typedef sefc_pkg::t_in  t_in;
    typedef sefc_pkg::t_out t_out;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_EVERY = 50;
    localparam int TAIL_CYCLES = 10;
    localparam int MAX_PRINTS  = 30;

    localparam logic [63:0] DEG_SCALE = 64'd3600000;   // 360 deg in 0.0001 deg units
    localparam logic [63:0] ROUND_HALF = 64'd524288;   // 2^19

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int frames_sent    = 0;
    int frames_decoded = 0;
    int frames_good    = 0;

    // Predicted held state of the decoder
    logic [ANGLE_W-1:0] pred_angle    = '0;
    logic [POS_W-1:0]   pred_pos      = '0;
    logic               pred_err_nv   = 1'b0;
    logic               pred_err_crc  = 1'b0;
    logic               pred_b32      = 1'b0;
    logic               pred_b30      = 1'b0;
    logic               pred_b7       = 1'b0;
    logic [CRC_W-1:0]   pred_crc_rx   = '0;
    logic [CRC_W-1:0]   pred_crc_calc = '0;

    t_out expected_results[$];

    always #(CLK_HALF) i_clk = ~i_clk;

    ssi_encoder_frame_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Augmented CRC-7 as long division of {data, 7 zeros} by x^7 + poly
    function automatic logic [CRC_W-1:0] crc7_of(input logic [CRC_DATA_W-1:0] data);
        logic [CRC_DATA_W+CRC_W-1:0] rem;
        rem = {data, {CRC_W{1'b0}}};
        for (int i = CRC_DATA_W + CRC_W - 1; i >= CRC_W; i--) begin
            if (rem[i]) begin
                rem[i -: CRC_W+1] = rem[i -: CRC_W+1] ^ {1'b1, CRC_POLY};
            end
        end
        return rem[CRC_W-1:0];
    endfunction

    // Decode one frame against the predicted state; returns the expected result
    function automatic t_out decode_frame(input t_in it);
        t_out             r;
        logic [CRC_W-1:0] calc;
        logic [63:0]      prod;
        r = '0;
        if (it.power_on && it.read_enable && !it.sequence_busy) begin
            calc           = crc7_of(it.frame[32:7]);
            r.read_active  = 1'b1;
            pred_pos       = it.frame[27:8];
            pred_b32       = it.frame[32];
            pred_b30       = it.frame[30];
            pred_b7        = it.frame[7];
            pred_crc_rx    = it.frame[6:0];
            pred_crc_calc  = calc;
            pred_err_nv    = !it.frame[31];
            pred_err_crc   = (it.frame[6:0] != calc);
            frames_decoded++;
            if (!pred_err_nv && !pred_err_crc) begin
                r.position_valid = 1'b1;
                prod       = 64'(pred_pos) * DEG_SCALE + ROUND_HALF;
                pred_angle = prod[20 +: ANGLE_W];
                frames_good++;
            end
        end
        r.error_not_valid = pred_err_nv;
        r.error_crc       = pred_err_crc;
        r.angle           = pred_angle;
        r.raw_position    = pred_pos;
        r.flag_bit32      = pred_b32;
        r.flag_bit30      = pred_b30;
        r.flag_bit7       = pred_b7;
        r.crc_received    = pred_crc_rx;
        r.crc_computed    = pred_crc_calc;
        return r;
    endfunction

    // Put the decoded fields over a base frame; CRC is correct or corrupted
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [FRAME_W-1:0] base,
        input logic               b32,
        input logic               b31,
        input logic               b30,
        input logic               b7,
        input logic [POS_W-1:0]   pos,
        input logic               crc_ok
    );
        logic [FRAME_W-1:0] f;
        logic [CRC_W-1:0]   flip;
        f       = base;
        f[32]   = b32;
        f[31]   = b31;
        f[30]   = b30;
        f[27:8] = pos;
        f[7]    = b7;
        flip    = CRC_W'($urandom_range(1, 127));
        f[6:0]  = crc7_of(f[32:7]) ^ (crc_ok ? '0 : flip);
        return f;
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        return FRAME_W'({$urandom, $urandom});
    endfunction

    function automatic t_in make_item(input logic pwr, input logic ren, input logic busy,
                                      input logic [FRAME_W-1:0] frame);
        t_in it;
        it.power_on      = pwr;
        it.read_enable   = ren;
        it.sequence_busy = busy;
        it.frame         = frame;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Send one input transaction, with random idle cycles ahead of it
    task automatic send_frame(input t_in it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        expected_results.push_back(decode_frame(it));
        frames_sent++;
    endtask

    // Stop sending until every expected result has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Gate closed right after reset: results show the zeroed held state
    task automatic test_closed_gate();
        send_frame(make_item(1'b0, 1'b0, 1'b0, '1));
        send_frame(make_item(1'b0, 1'b1, 1'b0, rand_frame()));
        send_frame(make_item(1'b1, 1'b0, 1'b0, rand_frame()));
        send_frame(make_item(1'b1, 1'b1, 1'b1, rand_frame()));
        hold_until_drained();
    endtask

    // Directed frames: extremes, rounding, each error cause, holds and recovery
    task automatic test_decode_cases();
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame('0, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b1)));
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame('1, 1'b1, 1'b1, 1'b1, 1'b1, '1, 1'b1)));
        // pos 4096 lands exactly on a half unit of angle
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame('0, 1'b0, 1'b1, 1'b0, 1'b0, 20'd4096, 1'b1)));
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame('0, 1'b0, 1'b1, 1'b0, 1'b0, 20'd1, 1'b1)));
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame(rand_frame(), 1'b0, 1'b1, 1'b0, 1'b1, 20'h80000, 1'b1)));
        // valid bit clear, CRC fine: angle must hold
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame(rand_frame(), 1'b1, 1'b0, 1'b1, 1'b0, 20'h12345, 1'b1)));
        send_frame(make_item(1'b0, 1'b1, 1'b0, rand_frame()));
        // CRC error only, then both errors
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame(rand_frame(), 1'b0, 1'b1, 1'b0, 1'b1, 20'hABCDE, 1'b0)));
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame(rand_frame(), 1'b1, 1'b0, 1'b1, 1'b1, 20'h00F0F, 1'b0)));
        send_frame(make_item(1'b1, 1'b1, 1'b0, '0));
        send_frame(make_item(1'b1, 1'b1, 1'b0, '1));
        send_frame(make_item(1'b1, 1'b1, 1'b1, rand_frame()));
        send_frame(make_item(1'b1, 1'b0, 1'b1, rand_frame()));
        // good frame after errors clears both flags
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame(rand_frame(), 1'b0, 1'b1, 1'b1, 1'b1,
                                         POS_W'($urandom), 1'b1)));
        send_frame(make_item(1'b1, 1'b1, 1'b0,
                             build_frame(rand_frame(), 1'b1, 1'b1, 1'b0, 1'b0,
                                         POS_W'($urandom), 1'b1)));
        hold_until_drained();
    endtask

    // Mostly well-formed frames with random content; the rest errors and noise
    task automatic send_random_frame();
        int               kind;
        logic [POS_W-1:0] pos;
        logic [2:0]       gate;
        kind = $urandom_range(99);
        case ($urandom_range(19))
            0:       pos = '0;
            1:       pos = '1;
            default: pos = POS_W'($urandom);
        endcase
        if (kind < 12) begin
            gate = 3'($urandom_range(7));
            send_frame(make_item(gate[2], gate[1], gate[0], rand_frame()));
        end else if (kind < 70) begin
            send_frame(make_item(1'b1, 1'b1, 1'b0,
                                 build_frame(rand_frame(), 1'($urandom), 1'b1, 1'($urandom),
                                             1'($urandom), pos, 1'b1)));
        end else if (kind < 85) begin
            send_frame(make_item(1'b1, 1'b1, 1'b0,
                                 build_frame(rand_frame(), 1'($urandom), 1'b1, 1'($urandom),
                                             1'($urandom), pos, 1'b0)));
        end else if (kind < 93) begin
            send_frame(make_item(1'b1, 1'b1, 1'b0,
                                 build_frame(rand_frame(), 1'($urandom), 1'b0, 1'($urandom),
                                             1'($urandom), pos, 1'($urandom))));
        end else begin
            send_frame(make_item(1'b1, 1'b1, 1'b0, rand_frame()));
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int n = 1; n <= PHASE_ITEMS; n++) begin
            send_random_frame();
            if (n % DRAIN_EVERY == 0) begin
                hold_until_drained();
            end
        end
        hold_until_drained();
    endtask

    // Result side back-pressure
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Compare each accepted result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result transaction", '0, '0);
            end else begin
                want = expected_results.pop_front();
                check_field("read_active", 32'(out_data.read_active),
                            32'(want.read_active));
                check_field("position_valid", 32'(out_data.position_valid),
                            32'(want.position_valid));
                check_field("error_not_valid", 32'(out_data.error_not_valid),
                            32'(want.error_not_valid));
                check_field("error_crc", 32'(out_data.error_crc),
                            32'(want.error_crc));
                check_field("angle", 32'(out_data.angle), 32'(want.angle));
                check_field("raw_position", 32'(out_data.raw_position),
                            32'(want.raw_position));
                check_field("flag_bit32", 32'(out_data.flag_bit32),
                            32'(want.flag_bit32));
                check_field("flag_bit30", 32'(out_data.flag_bit30),
                            32'(want.flag_bit30));
                check_field("flag_bit7", 32'(out_data.flag_bit7),
                            32'(want.flag_bit7));
                check_field("crc_received", 32'(out_data.crc_received),
                            32'(want.crc_received));
                check_field("crc_computed", 32'(out_data.crc_computed),
                            32'(want.crc_computed));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_closed_gate();
        test_decode_cases();
        test_random_phase(0, 0);
        test_random_phase(73, 0);
        test_random_phase(0, 73);
        test_random_phase(30, 30);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d frames: %0d decoded, %0d with a good position, %0d mismatches",
                 frames_sent, frames_decoded, frames_good, mismatch_count);
        $display("Covered closed-gate holds, CRC and valid-bit errors, angle extremes, "
                 , "rounding ties and four flow-control mixes with drain pauses");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
